/* sv/alcc_pkg.sv */
// Package with the types, constants and helper functions of the ASCII log CRC-32 checker.
`timescale 1ns / 1ps

package alcc_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [7:0]  CHAR_STAR = 8'h2A;
    localparam logic [7:0]  CHAR_0    = 8'h30;
    localparam logic [7:0]  CHAR_9    = 8'h39;
    localparam logic [7:0]  CHAR_UA   = 8'h41;
    localparam logic [7:0]  CHAR_UF   = 8'h46;
    localparam logic [7:0]  CHAR_LA   = 8'h61;
    localparam logic [7:0]  CHAR_LF   = 8'h66;
    localparam logic [3:0]  HEX_DIGITS = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_HEX  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] nibble;
    } hex_digit_t;

    // Reflected CRC-32 update over one byte, one bit per loop step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] v;
        v = {24'h00_0000, crc[7:0] ^ data};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return {8'h00, crc[31:8]} ^ v;
    endfunction

    // Decodes one ASCII hex digit in either case; anything else is bad and yields zero.
    function automatic hex_digit_t hex_value(input logic [7:0] c);
        hex_digit_t r;
        r.bad    = 1'b0;
        r.nibble = 4'h0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            r.nibble = 4'(c - CHAR_0);
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            r.nibble = 4'(c - CHAR_UA + 8'd10);
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            r.nibble = 4'(c - CHAR_LA + 8'd10);
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

/* sv/ascii_log_crc32_checker_unit.sv */
// Top level of the ASCII log CRC-32 checker: sentence framing, CRC update and hex compare.
//
//  Channel  Direction  Handshake         Payload
//  s_       in         s_valid/s_ready   s_rx_byte[7:0], s_msg_start
//  m_       out        m_valid/m_ready   m_crc_match, m_hex_error, m_computed_crc[31:0]
//
// The byte-wide CRC update and the hex decode sit between the sentence state registers
// and the result register, so one item is taken per cycle while the input is not stalled.
// A result appears in the cycle after the eighth hex digit is accepted.
// Reset clears the sentence state and the result valid flag; no clearing pass is needed.
// The input stalls only while a result is held and m_ready is low.
`timescale 1ns / 1ps

module ascii_log_crc32_checker_unit
    import alcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_msg_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_crc_match,
    output logic        m_hex_error,
    output logic [31:0] m_computed_crc
);

    phase_t      phase_reg, phase_next;
    logic [31:0] crc_acc_reg, crc_acc_next;
    logic [31:0] received_crc_reg, received_crc_next;
    logic [3:0]  digit_count_reg, digit_count_next;
    logic        bad_digit_seen_reg, bad_digit_seen_next;

    logic        m_valid_reg;
    logic        m_crc_match_reg;
    logic        m_hex_error_reg;
    logic [31:0] m_computed_crc_reg;

    logic        in_accept;
    logic        result_valid;
    logic        result_match;
    hex_digit_t  digit;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign digit     = hex_value(s_rx_byte);

    always_comb begin
        phase_next = phase_reg;
        if (s_msg_start) begin
            phase_next = PH_BODY;
        end else begin
            unique case (phase_reg)
                PH_BODY: begin
                    if (s_rx_byte == CHAR_STAR) begin
                        phase_next = PH_HEX;
                    end
                end
                PH_HEX: begin
                    if (digit_count_reg + 4'd1 >= HEX_DIGITS) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        crc_acc_next        = crc_acc_reg;
        received_crc_next   = received_crc_reg;
        digit_count_next    = digit_count_reg;
        bad_digit_seen_next = bad_digit_seen_reg;
        result_valid        = 1'b0;
        if (s_msg_start) begin
            crc_acc_next        = 32'h0000_0000;
            received_crc_next   = 32'h0000_0000;
            digit_count_next    = 4'd0;
            bad_digit_seen_next = 1'b0;
        end else begin
            unique case (phase_reg)
                PH_BODY: begin
                    if (s_rx_byte == CHAR_STAR) begin
                        received_crc_next   = 32'h0000_0000;
                        digit_count_next    = 4'd0;
                        bad_digit_seen_next = 1'b0;
                    end else begin
                        crc_acc_next = crc_byte(crc_acc_reg, s_rx_byte);
                    end
                end
                PH_HEX: begin
                    received_crc_next   = {received_crc_reg[27:0], digit.nibble};
                    bad_digit_seen_next = bad_digit_seen_reg || digit.bad;
                    digit_count_next    = digit_count_reg + 4'd1;
                    result_valid        = (digit_count_next >= HEX_DIGITS);
                end
                default: begin
                end
            endcase
        end
    end

    assign result_match = !bad_digit_seen_next && (received_crc_next == crc_acc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            crc_acc_reg        <= 32'h0000_0000;
            received_crc_reg   <= 32'h0000_0000;
            digit_count_reg    <= 4'd0;
            bad_digit_seen_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (in_accept) begin
                phase_reg          <= phase_next;
                crc_acc_reg        <= crc_acc_next;
                received_crc_reg   <= received_crc_next;
                digit_count_reg    <= digit_count_next;
                bad_digit_seen_reg <= bad_digit_seen_next;
            end
            if (in_accept && result_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && result_valid) begin
            m_crc_match_reg    <= result_match;
            m_hex_error_reg    <= bad_digit_seen_next;
            m_computed_crc_reg <= crc_acc_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_crc_match    = m_crc_match_reg;
    assign m_hex_error    = m_hex_error_reg;
    assign m_computed_crc = m_computed_crc_reg;

    // A finished sentence leaves the block idle with its result on offer.
    a_result_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && result_valid) |=> (m_valid_reg && phase_reg == PH_IDLE))
        else $error("result taken without returning to idle");

    // The digit counter never reaches eight while digits are still being collected.
    a_digit_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEX) |-> (digit_count_reg < HEX_DIGITS))
        else $error("digit count overran while collecting hex digits");

    // A reported match never comes with a bad hex digit.
    a_match_excludes_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_crc_match_reg) |-> !m_hex_error_reg)
        else $error("match reported together with a hex error");

    // A held result that is not taken keeps the input stalled.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while a result was stalled");

endmodule

/* verif/tb.sv */
// Testbench for the ASCII log CRC-32 checker: framed sentences in, CRC verdicts checked.
`timescale 1ns / 1ps

module tb;
    import alcc_pkg::*;

    localparam int ITEM_TARGET = 1200;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam logic [7:0] SYNC_CHAR = 8'h23;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LFD  = 8'h0A;

    typedef struct packed {
        logic        match;
        logic        hex_bad;
        logic [31:0] crc;
    } crc_report_t;

    typedef struct {
        logic [7:0]  lead;
        logic        lead_sync;
        string       tail;
        bit          pinned;
        crc_report_t want;
    } script_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        s_msg_start;
    logic        m_valid;
    logic        m_ready;
    logic        m_crc_match;
    logic        m_hex_error;
    logic [31:0] m_computed_crc;

    phase_t      pr_phase;
    logic [31:0] pr_crc;
    logic [31:0] pr_hex;
    logic [3:0]  pr_digits;
    logic        pr_bad;

    crc_report_t due_reports[$];
    crc_report_t head_report;
    script_row_t script[5];
    int          errors = 0;
    int          live_items = 0;
    int          quiet_cycles = 0;
    int          burst_left = 1;
    bit          drain_req = 1'b0;
    bit          drained = 1'b0;
    bit          long_hold_done = 1'b0;

    ascii_log_crc32_checker_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .s_msg_start   (s_msg_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_crc_match   (m_crc_match),
        .m_hex_error   (m_hex_error),
        .m_computed_crc(m_computed_crc)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        int k;
        c = crc ^ {24'h0, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // The top bit flags a character that is not a hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9) begin
            return {1'b0, 4'(c - CHAR_0)};
        end
        if (c >= CHAR_UA && c <= CHAR_UF) begin
            return {1'b0, 4'(c - CHAR_UA + 8'd10)};
        end
        if (c >= CHAR_LA && c <= CHAR_LF) begin
            return {1'b0, 4'(c - CHAR_LA + 8'd10)};
        end
        return 5'h10;
    endfunction

    function automatic bit crc_check_step(input logic [7:0] b, input logic sync,
                                          output crc_report_t rep);
        logic [4:0] d;
        rep = '0;
        if (sync) begin
            pr_phase  = PH_BODY;
            pr_crc    = '0;
            pr_hex    = '0;
            pr_digits = '0;
            pr_bad    = 1'b0;
            return 1'b0;
        end
        case (pr_phase)
            PH_BODY: begin
                if (b == CHAR_STAR) begin
                    pr_phase  = PH_HEX;
                    pr_hex    = '0;
                    pr_digits = '0;
                    pr_bad    = 1'b0;
                end else begin
                    pr_crc = crc_fold(pr_crc, b);
                end
            end
            PH_HEX: begin
                d = hex_nibble(b);
                pr_hex    = {pr_hex[27:0], d[3:0]};
                pr_bad    = pr_bad | d[4];
                pr_digits = pr_digits + 4'd1;
                if (pr_digits == HEX_DIGITS) begin
                    rep.match   = !pr_bad && (pr_hex == pr_crc);
                    rep.hex_bad = pr_bad;
                    rep.crc     = pr_crc;
                    pr_phase    = PH_IDLE;
                    return 1'b1;
                end
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic sync, input bit pinned,
                            input crc_report_t want);
        crc_report_t rep;
        int gap;
        s_valid     <= 1'b1;
        s_rx_byte   <= b;
        s_msg_start <= sync;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (sync || pr_phase != PH_IDLE) live_items++;
        if (crc_check_step(b, sync, rep)) begin
            due_reports.insert(due_reports.size(), pinned ? want : rep);
        end
        burst_left--;
        if (burst_left <= 0) begin
            gap = drain_req ? 1 : $urandom_range(0, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            if (drain_req) begin
                while (due_reports.size() != 0) @(posedge aclk);
                drain_req = 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic send_sentence();
        int body_len;
        int flavor;
        int spot;
        int k;
        logic [7:0]  ch;
        logic [31:0] sent;
        logic [3:0]  nib;
        put_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : SYNC_CHAR, 1'b1, 1'b0, '0);
        body_len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
        for (k = 0; k < body_len; k++) begin
            ch = 8'($urandom);
            if (ch == CHAR_STAR) ch = ~ch;
            put_byte(ch, 1'b0, 1'b0, '0);
        end
        flavor = $urandom_range(0, 11);
        spot   = $urandom_range(0, 7);
        if (flavor == 0) return;
        put_byte(CHAR_STAR, 1'b0, 1'b0, '0);
        sent = pr_crc;
        if (flavor == 1) sent[spot*4 +: 4] = sent[spot*4 +: 4] ^ 4'($urandom_range(1, 15));
        for (k = 0; k < 8; k++) begin
            nib = sent[31 - 4*k -: 4];
            if (nib < 4'd10) begin
                ch = CHAR_0 + 8'(nib);
            end else begin
                ch = ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(nib) - 8'd10;
            end
            if (flavor == 2 && k == spot) begin
                do ch = 8'($urandom); while (hex_nibble(ch) < 5'h10);
            end
            if (flavor == 3 && k == spot) return;
            put_byte(ch, 1'b0, 1'b0, '0);
        end
        repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LFD,
                                               1'b0, 1'b0, '0);
    endtask

    initial begin
        int r;
        int i;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_rx_byte   = 8'h00;
        s_msg_start = 1'b0;
        pr_phase    = PH_IDLE;
        pr_crc      = '0;
        pr_hex      = '0;
        pr_digits   = '0;
        pr_bad      = 1'b0;
        // Stray bytes while idle, an all-zero body that hashes to zero, a sentence cut
        // short by a new sync, and a sync byte that looks like the delimiter.
        script[0] = '{CHAR_CR, 1'b0, "\n", 1'b0, '0};
        script[1] = '{SYNC_CHAR, 1'b1, "", 1'b0, '0};
        script[2] = '{8'h00, 1'b0, "*00000000", 1'b1, '{1'b1, 1'b0, 32'h0}};
        script[3] = '{8'hFF, 1'b1, "\377*aB", 1'b0, '0};
        script[4] = '{CHAR_STAR, 1'b1, "*/:@G\140gCf", 1'b1, '{1'b0, 1'b1, 32'h0}};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (r = 0; r < 5; r++) begin
            put_byte(script[r].lead, script[r].lead_sync, script[r].pinned, script[r].want);
            for (i = 0; i < script[r].tail.len(); i++) begin
                put_byte(script[r].tail[i], 1'b0, script[r].pinned, script[r].want);
            end
        end
        while (live_items < ITEM_TARGET) begin
            if (!drained && live_items >= 800) begin
                drain_req = 1'b1;
                drained   = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom),
                                                       $urandom_range(0, 15) == 0, 1'b0, '0);
            end else begin
                send_sentence();
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : receiver
        int mode;
        int span;
        int tick;
        m_ready = 1'b0;
        tick = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span) begin
                if (!long_hold_done && live_items >= 500) begin
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                    long_hold_done = 1'b1;
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 3 != 2);
                endcase
                tick++;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual crc %h match %b",
                         $time, m_computed_crc, m_crc_match);
                errors++;
            end else begin
                head_report = due_reports.pop_front();
                if (m_crc_match !== head_report.match) begin
                    $display("%0t: crc_match expected %b actual %b",
                             $time, head_report.match, m_crc_match);
                    errors++;
                end
                if (m_hex_error !== head_report.hex_bad) begin
                    $display("%0t: hex_error expected %b actual %b",
                             $time, head_report.hex_bad, m_hex_error);
                    errors++;
                end
                if (m_computed_crc !== head_report.crc) begin
                    $display("%0t: computed_crc expected %h actual %h",
                             $time, head_report.crc, m_computed_crc);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
sv/alcc_pkg.sv
sv/ascii_log_crc32_checker_unit.sv
verif/tb.sv
